// ===== src/dfl_pkg.sv =====
// Shared types and constants for the descriptor free list.
package dfl_pkg;

  localparam int NumSlots = 256;
  localparam int SlotW    = $clog2(NumSlots);
  localparam int SizeW    = $clog2(NumSlots + 1);

  localparam logic [SizeW-1:0] SizeMax = SizeW'(NumSlots);
  localparam logic [SizeW-1:0] SizeMin = SizeW'(1);

  typedef enum logic [0:0] {
    OpAlloc   = 1'b0,
    OpRelease = 1'b1
  } dfl_op_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusRange = 2'd2
  } dfl_status_e;

  typedef struct packed {
    dfl_op_e            op;
    logic [SlotW-1:0]   slot_index;
  } dfl_req_t;

  typedef struct packed {
    dfl_status_e        status;
    logic [SlotW-1:0]   granted_slot;
    logic [SizeW-1:0]   free_count;
  } dfl_rsp_t;

  // Access to the link table: clear, read and write.
  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [SlotW-1:0]   rd_addr;
    logic               wr_en;
    logic [SlotW-1:0]   wr_addr;
    logic [SlotW-1:0]   wr_data;
  } dfl_mem_req_t;

endpackage

// ===== src/descriptor_free_list.sv =====
// A release or a failed allocate has its result loaded straight into the response register.
// A successful allocate first reads the link table in the lookup state, then registers its result.
// No new request is taken while an allocate is in the lookup state, where the registered link
// RAM read forms the new head; releases and failed allocates never leave the idle state.
// Reset and every size write rebuild the list at once, slots in ascending order.
module descriptor_free_list
  import dfl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dfl_req_t           in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dfl_rsp_t           out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [SizeW-1:0]   cfg_data_i
);

  typedef enum logic [1:0] {
    StateIdle   = 2'b01,
    StateLookup = 2'b10
  } dfl_state_e;

  dfl_state_e       state_q, state_d;
  logic [SlotW-1:0] head_q, head_d;
  logic [SizeW-1:0] free_q, free_d;
  logic [SizeW-1:0] size_q, size_d;
  logic             out_valid_q, out_valid_d;
  dfl_rsp_t         rsp_q, rsp_d;
  logic             rsp_load;
  dfl_mem_req_t     mem_req;
  logic [SlotW-1:0] link_data;
  logic             in_fire, cfg_fire;
  logic [SizeW-1:0] cfg_size;

  assign cfg_ready_o = (state_q == StateIdle);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == StateIdle) && (!out_valid_q || out_ready_i) && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign cfg_size = (cfg_data_i == '0) ? SizeMin
                  : ((cfg_data_i > SizeMax) ? SizeMax : cfg_data_i);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    free_d   = free_q;
    size_d   = size_q;
    rsp_d    = rsp_q;
    rsp_load = 1'b0;
    mem_req  = '0;
    case (state_q)
      StateIdle: begin
        if (cfg_fire) begin
          size_d        = cfg_size;
          head_d        = '0;
          free_d        = cfg_size;
          mem_req.clear = 1'b1;
        end else if (in_fire) begin
          rsp_d.granted_slot = '0;
          if (in_req_i.op == OpAlloc) begin
            if (free_q == '0) begin
              rsp_d.status     = StatusEmpty;
              rsp_d.free_count = free_q;
              rsp_load         = 1'b1;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = head_q;
              state_d         = StateLookup;
            end
          end else begin
            if ({1'b0, in_req_i.slot_index} >= size_q) begin
              rsp_d.status     = StatusRange;
              rsp_d.free_count = free_q;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = in_req_i.slot_index;
              mem_req.wr_data = head_q;
              head_d          = in_req_i.slot_index;
              // A double release must not push the count past the slot count.
              if (free_q < size_q) begin
                free_d = free_q + SizeW'(1);
              end
              rsp_d.status     = StatusOk;
              rsp_d.free_count = free_d;
            end
            rsp_load = 1'b1;
          end
        end
      end
      StateLookup: begin
        head_d             = link_data;
        free_d             = free_q - SizeW'(1);
        rsp_d.status       = StatusOk;
        rsp_d.granted_slot = head_q;
        rsp_d.free_count   = free_d;
        rsp_load           = 1'b1;
        state_d            = StateIdle;
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || rsp_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      head_q      <= '0;
      free_q      <= SizeMax;
      size_q      <= SizeMax;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  dfl_link_mem u_link_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .size_i    (size_q),
    .rd_data_o (link_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef ASSERT_OFF
  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= size_q)
    else $error("free count exceeds the number of slots in use");

  a_alloc_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i.op == OpAlloc && free_q != '0) |=> (state_q == StateLookup))
    else $error("allocate with free slots did not read the link table");

  a_lookup_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateLookup) |=> (out_valid_o && state_q == StateIdle))
    else $error("allocate lookup did not produce a result");

  a_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> (free_q == size_q && head_q == '0 && !in_fire))
    else $error("size write did not rebuild the free list");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !rsp_load)
    else $error("result overwritten before it was taken");
`endif

endmodule

// ===== src/dfl_link_mem.sv =====
// Link table of the free list: synchronous RAM plus per-entry written flags.
module dfl_link_mem
  import dfl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfl_mem_req_t       mem_req_i,
  input  logic [SizeW-1:0]   size_i,
  output logic [SlotW-1:0]   rd_data_o
);

  logic [SlotW-1:0] mem [NumSlots];
  logic [NumSlots-1:0] written_q;
  logic [SlotW-1:0] mem_data_q;
  logic [SlotW-1:0] rd_addr_q;
  logic             rd_written_q;
  logic [SizeW-1:0] next_idx;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      mem_data_q <= mem[mem_req_i.rd_addr];
      rd_addr_q  <= mem_req_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (mem_req_i.clear) begin
        written_q <= '0;
      end else if (mem_req_i.wr_en) begin
        written_q[mem_req_i.wr_addr] <= 1'b1;
      end
      if (mem_req_i.rd_en) begin
        rd_written_q <= written_q[mem_req_i.rd_addr];
      end
    end
  end

  // An entry never written since the last rebuild links to the next slot,
  // and the last slot in use links back to zero.
  assign next_idx  = {1'b0, rd_addr_q} + SizeW'(1);
  assign rd_data_o = rd_written_q ? mem_data_q
                   : ((next_idx < size_i) ? next_idx[SlotW-1:0] : '0);

endmodule

// ===== tb/sv/tb_descriptor_free_list.sv =====
// Self-checking testbench for the descriptor free list allocator.
`timescale 1ns / 100ps

module tb_descriptor_free_list;
  import dfl_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  dfl_req_t         in_req_i;
  logic             out_valid_o;
  logic             out_ready_i;
  dfl_rsp_t         out_rsp_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i;

  // Shadow copy of the free list, updated as each request is accepted.
  logic [SlotW-1:0] link_tbl [NumSlots];
  logic [SlotW-1:0] head_slot;
  logic [SizeW-1:0] free_slots;
  logic [SizeW-1:0] size_reg;

  dfl_rsp_t         rsp_due_q [$];
  logic [SlotW-1:0] held_q [$];
  int               fail_count = 0;
  bit               gaps_on = 1'b0;
  bit               stalls_on = 1'b0;
  int               stall_left = 0;

  descriptor_free_list DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Sizes of zero and above the table act as the nearest legal size.
  function automatic logic [SizeW-1:0] active_size();
    if (size_reg == '0) return SizeMin;
    if (size_reg > SizeMax) return SizeMax;
    return size_reg;
  endfunction

  function automatic void rebuild_list();
    logic [SizeW-1:0] s;
    s = active_size();
    for (int i = 0; i < NumSlots; i++) begin
      link_tbl[i] = (i + 1 < int'(s)) ? SlotW'(i + 1) : '0;
    end
    head_slot  = '0;
    free_slots = s;
  endfunction

  function automatic dfl_rsp_t apply_request(dfl_req_t req);
    dfl_rsp_t         rsp;
    logic [SizeW-1:0] s;
    s = active_size();
    rsp.status       = StatusOk;
    rsp.granted_slot = '0;
    if (req.op == OpAlloc) begin
      if (free_slots == '0) begin
        rsp.status = StatusEmpty;
      end else begin
        rsp.granted_slot = head_slot;
        head_slot        = link_tbl[head_slot];
        free_slots       = free_slots - 1'b1;
      end
    end else begin
      if ({1'b0, req.slot_index} >= s) begin
        rsp.status = StatusRange;
      end else begin
        link_tbl[req.slot_index] = head_slot;
        head_slot                = req.slot_index;
        // A double release is taken, but the count never passes the size.
        if (free_slots < s) free_slots = free_slots + 1'b1;
      end
    end
    rsp.free_count = free_slots;
    return rsp;
  endfunction

  task automatic send_request(input dfl_op_e op, input logic [SlotW-1:0] slot);
    dfl_req_t req;
    dfl_rsp_t rsp;
    int       gap;
    req.op         = op;
    req.slot_index = slot;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    rsp = apply_request(req);
    rsp_due_q.push_back(rsp);
    if (op == OpAlloc && rsp.status == StatusOk) held_q.push_back(rsp.granted_slot);
  endtask

  // Stops sending and waits until every request has its response.
  task automatic drain_responses();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_queue_size(input logic [SizeW-1:0] value);
    drain_responses();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = value;
    rebuild_list();
    held_q.delete();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic release_some_slot();
    int               pick;
    int               idx;
    logic [SlotW-1:0] slot;
    pick = $urandom_range(0, 9);
    if (pick < 8 && held_q.size() != 0) begin
      idx  = $urandom_range(0, held_q.size() - 1);
      slot = held_q[idx];
      held_q.delete(idx);
    end else if (pick < 9) begin
      slot = SlotW'($urandom_range(0, int'(active_size()) - 1));
    end else begin
      slot = SlotW'($urandom_range(0, NumSlots - 1));
    end
    send_request(OpRelease, slot);
  endtask

  task automatic test_reset_list();
    send_request(OpAlloc, 8'hFF);
    send_request(OpAlloc, 8'h00);
    send_request(OpRelease, 8'hFF);
    send_request(OpAlloc, 8'h5A);
    send_request(OpRelease, 8'h00);
    send_request(OpRelease, 8'h01);
    send_request(OpRelease, 8'hFF);
    // Releasing a slot that is already free must not push the count past the size.
    send_request(OpRelease, 8'h00);
    send_request(OpAlloc, 8'h00);
  endtask

  task automatic test_empty_and_range();
    write_queue_size('0);
    send_request(OpRelease, 8'h01);
    send_request(OpRelease, 8'hFF);
    send_request(OpAlloc, 8'hFF);
    send_request(OpAlloc, 8'h00);
    send_request(OpRelease, 8'h00);
    write_queue_size(SizeMin);
    send_request(OpAlloc, 8'h00);
    send_request(OpAlloc, 8'h00);
  endtask

  task automatic test_size_clamp();
    write_queue_size('1);
    send_request(OpAlloc, 8'h00);
    send_request(OpRelease, 8'hFF);
    send_request(OpAlloc, 8'hFF);
    write_queue_size(SizeMax);
    send_request(OpRelease, 8'h80);
    send_request(OpAlloc, 8'h7F);
  endtask

  task automatic test_random_traffic();
    logic [SizeW-1:0] sizes [12];
    int               run_left;
    bit               fill;
    int               count;
    sizes = '{9'd2, 9'd3, 9'd5, 9'd256, 9'd8, 9'd1, 9'd16, 9'd511, 9'd4, 9'd0, 9'd7, 9'd300};
    foreach (sizes[p]) begin
      write_queue_size(sizes[p]);
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      run_left  = 0;
      fill      = 1'b1;
      count     = (active_size() > 16) ? 190 : 110;
      for (int n = 0; n < count; n++) begin
        // Alternate stretches that lean toward filling and toward emptying the list.
        if (run_left == 0) begin
          run_left = $urandom_range(5, 40);
          fill     = ~fill;
        end
        run_left--;
        if ($urandom_range(0, 3) != 0 ? !fill : fill) begin
          send_request(OpAlloc, SlotW'($urandom_range(0, NumSlots - 1)));
        end else begin
          release_some_slot();
        end
      end
    end
    write_queue_size(9'($urandom_range(1, 511)));
    for (int n = 0; n < 60; n++) begin
      if ($urandom_range(0, 1) == 0) send_request(OpAlloc, SlotW'($urandom));
      else release_some_slot();
    end
  endtask

  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_queue_size(SizeMax);
    repeat (40) send_request(OpAlloc, 8'h00);
    while (held_q.size() != 0) release_some_slot();
    write_queue_size(9'd4);
    for (int n = 0; n < 60; n++) begin
      if ($urandom_range(0, 1) == 0) send_request(OpAlloc, 8'h00);
      else release_some_slot();
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dfl_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_due_q.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        want = rsp_due_q.pop_front();
        if (out_rsp_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_rsp_o.status);
          fail_count++;
        end
        if (out_rsp_o.granted_slot !== want.granted_slot) begin
          $error("granted_slot: expected %0d, actual %0d",
                 want.granted_slot, out_rsp_o.granted_slot);
          fail_count++;
        end
        if (out_rsp_o.free_count !== want.free_count) begin
          $error("free_count: expected %0d, actual %0d",
                 want.free_count, out_rsp_o.free_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    size_reg    = SizeMax;
    rebuild_list();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_list();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_empty_and_range();
    test_size_clamp();
    test_random_traffic();
    test_back_to_back();

    drain_responses();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && rsp_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dfl_pkg.sv
src/dfl_link_mem.sv
src/descriptor_free_list.sv
tb/sv/tb_descriptor_free_list.sv
